@@ rtl/core/sck_pkg.sv @@
package sck_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 256;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = AW + 1;

	// Item actions.
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_UPDATED   = 3'd1;
	localparam logic [2:0] ST_REFUSED   = 3'd2;
	localparam logic [2:0] ST_NOSTORE   = 3'd3;
	localparam logic [2:0] ST_REMOVED   = 3'd4;
	localparam logic [2:0] ST_CLEARED   = 3'd5;

	// One table entry: sort key followed by its box.
	typedef struct packed {
		logic signed [31:0] kx;
		logic signed [31:0] ky;
		logic signed [31:0] kz;
		logic [63:0]        own;
		logic [63:0]        itm;
		logic [5:0][63:0]   box;
	} entry_t;

	localparam int EW = $bits(entry_t);

	// Result handed from the sequencer to the output register.
	typedef struct packed {
		logic [2:0]    status;
		logic [CW-1:0] removed;
		logic [CW-1:0] entries;
		logic [31:0]   refused;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRD,
		S_SCMP,
		S_EQCMP,
		S_DECIDE,
		S_SHRD,
		S_SHWR,
		S_RRD,
		S_RCMP,
		S_DONE
	} state_t;

	// Sort key as one unsigned word: signed fields get their sign bit flipped.
	function automatic logic [223:0] sort_key(input entry_t e);
		sort_key = {~e.kx[31], e.kx[30:0], ~e.ky[31], e.ky[30:0],
			~e.kz[31], e.kz[30:0], e.own, e.itm};
	endfunction

endpackage

@@ rtl/core/sck_ram.sv @@
module sck_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/sck_ctrl.sv @@
module sck_ctrl
	import sck_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    act,
	input  entry_t        ent,
	input  logic [CW-1:0] cap,
	input  logic          out_free,
	output logic          busy,
	output logic          res_valid,
	output result_t       res,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output entry_t        wr_data,
	output logic [AW-1:0] rd_addr,
	input  entry_t        rd_data
);

	state_t state_q, state_d;

	entry_t        ent_q;
	logic [CW-1:0] lo_q, hi_q, idx_q, w_q, fill_q, removed_q;
	logic [31:0]   refused_q;
	logic [2:0]    status_q;
	logic          eq_q;
	logic [CW-1:0] mid;
	logic          probe_le, probe_eq, owner_hit;

	// Midpoint of the search window and compares against the read entry.
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign probe_le  = sort_key(ent_q) <= sort_key(rd_data);
	assign probe_eq  = sort_key(ent_q) == sort_key(rd_data);
	assign owner_hit = rd_data.own == ent_q.own;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (act)
						ACT_INSERT: state_d = (cap == '0) ? S_DONE : S_SRD;
						ACT_REMOVE: state_d = (ent.own == '0) ? S_DONE : S_RRD;
						ACT_CLEAR:  state_d = S_DONE;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_SRD: begin
				if (lo_q < hi_q) begin
					state_d = S_SCMP;
				end else if (lo_q < fill_q) begin
					state_d = S_EQCMP;
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_SCMP:   state_d = S_SRD;
			S_EQCMP:  state_d = S_DECIDE;
			S_DECIDE: state_d = (eq_q || fill_q >= cap) ? S_DONE : S_SHRD;
			S_SHRD:   state_d = (idx_q > lo_q) ? S_SHWR : S_DONE;
			S_SHWR:   state_d = S_SHRD;
			S_RRD:    state_d = (idx_q < fill_q) ? S_RCMP : S_DONE;
			S_RCMP:   state_d = S_RRD;
			S_DONE:   state_d = out_free ? S_IDLE : S_DONE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Memory accesses; the handshake outputs are assigned after this block.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = lo_q[AW-1:0];
		wr_data = ent_q;
		rd_addr = idx_q[AW-1:0];
		case (state_q)
			S_SRD: begin
				rd_addr = (lo_q < hi_q) ? mid[AW-1:0] : lo_q[AW-1:0];
			end
			S_DECIDE: begin
				wr_en = eq_q;
			end
			S_SHRD: begin
				rd_addr = idx_q[AW-1:0] - 1'b1;
				wr_en   = !(idx_q > lo_q);
			end
			S_SHWR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[AW-1:0];
				wr_data = rd_data;
			end
			S_RCMP: begin
				wr_en   = !owner_hit && (w_q != idx_q);
				wr_addr = w_q[AW-1:0];
				wr_data = rd_data;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign busy      = state_q != S_IDLE;
	assign res_valid = (state_q == S_DONE) && out_free;
	assign res       = '{status: status_q, removed: removed_q, entries: fill_q,
		refused: refused_q};

	// State and control counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			refused_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (start && act == ACT_CLEAR) begin
						fill_q <= '0;
					end
				end
				S_DECIDE: begin
					if (!eq_q && fill_q >= cap && refused_q != '1) begin
						refused_q <= refused_q + 1'b1;
					end
				end
				S_SHRD: begin
					if (!(idx_q > lo_q)) begin
						fill_q <= fill_q + 1'b1;
					end
				end
				S_RRD: begin
					if (!(idx_q < fill_q)) begin
						fill_q <= w_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Item registers, search window and walk indices.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ent_q     <= ent;
				lo_q      <= '0;
				hi_q      <= fill_q;
				idx_q     <= '0;
				w_q       <= '0;
				removed_q <= '0;
				eq_q      <= 1'b0;
				case (act)
					ACT_INSERT: status_q <= ST_NOSTORE;
					ACT_REMOVE: status_q <= ST_REMOVED;
					default:    status_q <= ST_CLEARED;
				endcase
			end
			S_SCMP: begin
				if (probe_le) begin
					hi_q <= mid;
				end else begin
					lo_q <= mid + 1'b1;
				end
			end
			S_SRD: begin
				if (!(lo_q < hi_q)) begin
					idx_q <= fill_q;
				end
			end
			S_EQCMP: begin
				eq_q <= probe_eq;
			end
			S_DECIDE: begin
				if (eq_q) begin
					status_q <= ST_UPDATED;
				end else if (fill_q >= cap) begin
					status_q <= ST_REFUSED;
				end else begin
					status_q <= ST_INSERTED;
				end
			end
			S_SHWR: begin
				idx_q <= idx_q - 1'b1;
			end
			S_RCMP: begin
				if (owner_hit) begin
					removed_q <= removed_q + 1'b1;
				end else begin
					w_q <= w_q + 1'b1;
				end
				idx_q <= idx_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

`ifndef ASSERT_OFF
	// The entry count never passes the table depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	// No memory write while no item is in progress.
	a_idle_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !wr_en)
		else $error("table write while idle");

	// During a remove every visited entry is either kept or counted.
	a_remove_sum: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RRD |-> removed_q + w_q == idx_q)
		else $error("remove walk lost an entry");

	// The refusal count never goes down.
	a_refused_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> refused_q >= $past(refused_q))
		else $error("refusal count decreased");
`endif

endmodule

@@ rtl/core/sorted_chunk_key_index.sv @@
// Sorted table of keyed entries with boxes.
// Input channel (in_valid/in_stall): one item per handshake with an action of
// insert or update, remove all entries of an owner, or clear. The action code
// three is taken and dropped without a result.
// Output channel (out_valid/out_stall): one item per accepted action but code
// three, with its status, removed count, entry count and refusal total.
// in_stall is high while an item is in progress; one item is worked at a time.
// Per item, with F entries: insert or update runs a binary search of B steps
// (at most log2(depth) + 1) and an insert then moves each entry above its
// position up one; a clear does none of this and a remove walks all F entries
// (none for owner zero), with one entry memory read per search step or entry.
// The result waits in an output register, so the next item is taken while
// out_stall holds a result; the sequencer only waits when it finishes
// another item with that register still full.
// Reset empties the table, clears the refusal count and sets the capacity to
// the full depth; the entry memory is not cleared. cfg_we writes the capacity
// in use; the user must do so only while the block is idle (not enforced).
module sorted_chunk_key_index
	import sck_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [8:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic signed [31:0] chunk_x,
	input  logic signed [31:0] chunk_y,
	input  logic signed [31:0] chunk_z,
	input  logic [63:0]        owner_id,
	input  logic [63:0]        item_id,
	input  logic signed [63:0] box_min_x,
	input  logic signed [63:0] box_min_y,
	input  logic signed [63:0] box_min_z,
	input  logic signed [63:0] box_max_x,
	input  logic signed [63:0] box_max_y,
	input  logic signed [63:0] box_max_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [8:0]         removed_count,
	output logic [8:0]         entry_count,
	output logic [31:0]        refused_total
);

	logic [8:0]    cap_q;
	logic [CW-1:0] cap_eff;
	logic          busy, start, out_free, res_valid;
	result_t       res, res_q;
	entry_t        ent, wr_data, rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic          out_valid_q;

	// Capacity register, limited to the table depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 9'(TABLE_DEPTH);
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	assign cap_eff = (int'(cap_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(cap_q);

	assign in_stall = busy;
	assign start    = in_valid && !busy;
	assign out_free = !out_valid_q || !out_stall;

	assign ent = '{kx: chunk_x, ky: chunk_y, kz: chunk_z, own: owner_id, itm: item_id,
		box: {box_max_z, box_max_y, box_max_x, box_min_z, box_min_y, box_min_x}};

	sck_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.act      (action),
		.ent      (ent),
		.cap      (cap_eff),
		.out_free (out_free),
		.busy     (busy),
		.res_valid(res_valid),
		.res      (res),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	sck_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = res_q.status;
	assign removed_count = 9'(res_q.removed);
	assign entry_count   = 9'(res_q.entries);
	assign refused_total = res_q.refused;

endmodule
